@@ rtl/ilp_pkg.sv @@
// Shared definitions for the integer literal parser.
// Holds the character codes and number base codes; depends on nothing.
package ilp_pkg;

	// Characters with a special role in a literal.
	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_OCT   = 8'h6F;  // 'o'
	localparam logic [7:0] CH_HEX   = 8'h78;  // 'x'
	localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
	localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'

	// Number base of the digits being collected.
	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

endpackage

@@ rtl/integer_literal_parser.sv @@
// Integer literal parser: one character per cycle, one result per text; uses ilp_pkg.
// A character is registered in the input stage, then evaluated; the result of a last character
// is loaded into the output register as soon as the output register is free to take it.
// Throughput: one character per cycle, set by the shift-add and compare on the magnitude;
// a last character waits only while the output holds a stalled result.
// Reset (arst_n, asynchronous, active low) empties both stages and restarts the text.
module integer_literal_parser
	import ilp_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   char_code,
	input  logic                         last_char,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         is_integer,
	output logic signed [VALUE_BITS-1:0] int_value
);

	// Accumulator width with room for a radix of 16 and an added digit.
	localparam int W = VALUE_BITS + 5;
	// Largest magnitude ever held: 2^(VALUE_BITS-1).
	localparam logic [W-1:0] LIM = {5'b0, 1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_SIGN   = 3'd1,
		PH_ZERO   = 3'd2,
		PH_PREFIX = 3'd3,
		PH_DIGITS = 3'd4,
		PH_ERROR  = 3'd5
	} phase_t;

	// Input stage.
	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  last_s1;

	// Parser state.
	phase_t                phase_q;
	logic                  neg_q;
	base_t                 base_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  ovf_q;

	// Output register.
	logic                  out_valid_q;
	logic                  is_int_q;
	logic [VALUE_BITS-1:0] value_q;

	// Next state and result.
	phase_t                phase_n;
	logic                  neg_n;
	base_t                 base_n;
	logic [VALUE_BITS-1:0] mag_n;
	logic                  ovf_n;
	logic                  ok_n;
	logic [VALUE_BITS-1:0] value_n;

	logic                  adv_s1;
	logic                  take_in;
	logic                  out_free;
	base_t                 dig_base;
	logic                  dig_ok;
	logic [3:0]            dig_val;
	logic                  do_acc;
	logic [W-1:0]          mag_ext;
	logic [W-1:0]          scaled;
	logic [W-1:0]          acc_sum;
	logic [W-1:0]          max_mag;

	// Handshake: the input stage moves on unless its result would hit a full output.
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = !last_s1 || out_free;
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	// Digit decode in the base the current phase calls for.
	always_comb begin
		dig_base = (phase_q == PH_PREFIX || phase_q == PH_DIGITS) ? base_q : BASE_DEC;
		dig_ok   = 1'b0;
		dig_val  = 4'd0;
		case (char_s1) inside
			[8'h30:8'h37]: begin
				dig_ok  = 1'b1;
				dig_val = char_s1[3:0];
			end
			[8'h38:8'h39]: begin
				dig_ok  = (dig_base != BASE_OCT);
				dig_val = char_s1[3:0];
			end
			[8'h61:8'h66], [8'h41:8'h46]: begin
				dig_ok  = (dig_base == BASE_HEX);
				dig_val = 4'(char_s1[2:0] + 3'd1) + 4'd8;
			end
			default: begin
				dig_ok  = 1'b0;
			end
		endcase
	end

	// Shift-add of one digit; the sum passing 2^(VALUE_BITS-1) means overflow.
	always_comb begin
		mag_ext = {5'b0, mag_q};
		case (base_q)
			BASE_HEX: scaled = mag_ext << 4;
			BASE_OCT: scaled = mag_ext << 3;
			default:  scaled = (mag_ext << 3) + (mag_ext << 1);
		endcase
		if (phase_q == PH_PREFIX || phase_q == PH_DIGITS) begin
			acc_sum = scaled + W'(dig_val);
		end else begin
			acc_sum = W'(dig_val);
		end
	end

	// Phase update for the character in the input stage.
	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		base_n  = base_q;
		do_acc  = 1'b0;
		case (phase_q)
			PH_START, PH_SIGN: begin
				if (phase_q == PH_START && (char_s1 == CH_PLUS || char_s1 == CH_MINUS)) begin
					neg_n   = (char_s1 == CH_MINUS);
					phase_n = PH_SIGN;
				end else if (char_s1 == CH_ZERO) begin
					phase_n = PH_ZERO;
				end else if (dig_ok) begin
					do_acc  = 1'b1;
					phase_n = PH_DIGITS;
				end else begin
					phase_n = PH_ERROR;
				end
			end
			PH_ZERO: begin
				if (!last_s1 && char_s1 == CH_OCT) begin
					base_n  = BASE_OCT;
					phase_n = PH_PREFIX;
				end else if (!last_s1 && char_s1 == CH_HEX) begin
					base_n  = BASE_HEX;
					phase_n = PH_PREFIX;
				end else if (dig_ok) begin
					do_acc  = 1'b1;
					phase_n = PH_DIGITS;
				end else begin
					phase_n = PH_ERROR;
				end
			end
			PH_PREFIX, PH_DIGITS: begin
				if (dig_ok) begin
					do_acc  = 1'b1;
					phase_n = PH_DIGITS;
				end else begin
					phase_n = PH_ERROR;
				end
			end
			default: begin
				phase_n = PH_ERROR;
			end
		endcase

		// The overflow flag is sticky and freezes the magnitude.
		mag_n = mag_q;
		ovf_n = ovf_q;
		if (do_acc && !ovf_q) begin
			if (acc_sum > LIM) begin
				ovf_n = 1'b1;
			end else begin
				mag_n = acc_sum[VALUE_BITS-1:0];
			end
		end

		// Final verdict; a positive value stops one below the limit.
		max_mag = neg_n ? LIM : LIM - W'(1);
		ok_n    = (phase_n == PH_ZERO || phase_n == PH_DIGITS) && !ovf_n
		          && ({5'b0, mag_n} <= max_mag);
		if (!ok_n) begin
			value_n = '0;
		end else if (neg_n) begin
			value_n = {VALUE_BITS{1'b0}} - mag_n;
		end else begin
			value_n = mag_n;
		end
	end

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// Parser state; a last character returns it to the start of a text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			base_q  <= BASE_DEC;
			mag_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			if (last_s1) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				base_q  <= BASE_DEC;
				mag_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				base_q  <= base_n;
				mag_q   <= mag_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	// Output register, loaded by a last character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && last_s1) begin
			is_int_q <= ok_n;
			value_q  <= value_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_integer = is_int_q;
	assign int_value  = value_q;

endmodule

@@ sim/tb_integer_literal_parser.sv @@
// Self-checking testbench for integer_literal_parser: streams literal texts one character per
// beat and checks each verdict and value against a cycle-free parser model kept in this file.
// Depends on ilp_pkg and integer_literal_parser from the rtl folder.
module tb_integer_literal_parser
	import ilp_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TEXT_CHARS   = 1400;
	localparam int          TAIL_CHARS   = 150;
	localparam int          QUIET_LIMIT  = 2000;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          REPORT_MAX   = 10;
	localparam logic [63:0] MAG_LIMIT    = 64'h8000_0000_0000_0000;
	localparam string       ODD_CHARS    = "+-0ox789aFfgGz";

	// Phases of the model parser.
	typedef enum logic [2:0] {
		PH_START,
		PH_SIGN,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	typedef struct packed {
		logic               ok;
		logic signed [63:0] value;
	} literal_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         char_code = 8'h00;
	logic               last_char = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               is_integer;
	logic signed [63:0] int_value;

	// Characters waiting to be sent and verdicts waiting to arrive.
	text_char_t      pending[$];
	literal_result_t expected_literals[$];
	logic [7:0]      txt[$];
	int              queued_chars = 0;

	// Model parser state.
	phase_t      lit_phase = PH_START;
	logic        lit_neg = 1'b0;
	base_t       lit_base = BASE_DEC;
	logic [63:0] lit_mag = '0;
	logic        lit_ovf = 1'b0;

	int              send_gap = 0;
	int              recv_gap = 0;
	int              errors = 0;
	int              quiet_cycles = 0;
	text_char_t      beat;
	literal_result_t want;

	integer_literal_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.is_integer (is_integer),
		.int_value  (int_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The last stretch of the run goes without idling on either side.
	function automatic bit in_tail();
		return pending.size() < TAIL_CHARS;
	endfunction

	// Value of a character as a digit of the given base, or -1.
	function automatic int digit_of(logic [7:0] ch, base_t base);
		if (ch >= "0" && ch <= "9") begin
			if (base == BASE_OCT && ch > "7") begin
				return -1;
			end
			return int'(ch - CH_ZERO);
		end
		if (base == BASE_HEX && ch >= "a" && ch <= "f") begin
			return int'(ch - "a") + 10;
		end
		if (base == BASE_HEX && ch >= "A" && ch <= "F") begin
			return int'(ch - "A") + 10;
		end
		return -1;
	endfunction

	// Character for a digit; letters come in either case.
	function automatic logic [7:0] digit_char(int d);
		if (d < 10) begin
			return 8'(int'(CH_ZERO) + d);
		end
		return 8'(int'($urandom_range(0, 1) ? "A" : "a") + d - 10);
	endfunction

	// Shift one digit into the magnitude; the overflow flag is sticky.
	task automatic fold_digit(input int d);
		logic [63:0] radix;
		radix = (lit_base == BASE_HEX) ? 64'd16 : (lit_base == BASE_OCT) ? 64'd8 : 64'd10;
		if (!lit_ovf) begin
			if (lit_mag > (MAG_LIMIT - 64'(d)) / radix) begin
				lit_ovf = 1'b1;
			end else begin
				lit_mag = lit_mag * radix + 64'(d);
			end
		end
	endtask

	// Advance the model parser by one character; a last character yields a verdict.
	task automatic scan_char(input logic [7:0] ch, input logic fin);
		int              d;
		logic [63:0]     max_mag;
		literal_result_t res;
		case (lit_phase)
			PH_START, PH_SIGN: begin
				d = digit_of(ch, BASE_DEC);
				if (lit_phase == PH_START && (ch == CH_PLUS || ch == CH_MINUS)) begin
					lit_neg = (ch == CH_MINUS);
					lit_phase = PH_SIGN;
				end else if (ch == CH_ZERO) begin
					lit_phase = PH_ZERO;
				end else if (d >= 0) begin
					fold_digit(d);
					lit_phase = PH_DIGITS;
				end else begin
					lit_phase = PH_ERROR;
				end
			end
			PH_ZERO: begin
				d = digit_of(ch, BASE_DEC);
				if (!fin && ch == CH_OCT) begin
					lit_base = BASE_OCT;
					lit_phase = PH_PREFIX;
				end else if (!fin && ch == CH_HEX) begin
					lit_base = BASE_HEX;
					lit_phase = PH_PREFIX;
				end else if (d >= 0) begin
					fold_digit(d);
					lit_phase = PH_DIGITS;
				end else begin
					lit_phase = PH_ERROR;
				end
			end
			PH_PREFIX, PH_DIGITS: begin
				d = digit_of(ch, lit_base);
				if (d >= 0) begin
					fold_digit(d);
					lit_phase = PH_DIGITS;
				end else begin
					lit_phase = PH_ERROR;
				end
			end
			default: begin
				lit_phase = PH_ERROR;
			end
		endcase
		if (fin) begin
			max_mag = lit_neg ? MAG_LIMIT : MAG_LIMIT - 64'd1;
			res.ok = (lit_phase == PH_ZERO || lit_phase == PH_DIGITS) && !lit_ovf
				&& lit_mag <= max_mag;
			res.value = res.ok ? (lit_neg ? -lit_mag : lit_mag) : '0;
			expected_literals = {expected_literals, res};
			lit_phase = PH_START;
			lit_neg = 1'b0;
			lit_base = BASE_DEC;
			lit_mag = '0;
			lit_ovf = 1'b0;
		end
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			txt = {txt, s[i]};
		end
	endtask

	// Move the text under construction into the send queue, marking its final character.
	task automatic queue_text();
		text_char_t c;
		for (int i = 0; i < txt.size(); i++) begin
			c.code = txt[i];
			c.last = (i == txt.size() - 1);
			pending = {pending, c};
		end
		queued_chars += txt.size();
		txt.delete();
	endtask

	// Build one random text: mostly well-formed literals, some damaged ones, some noise.
	task automatic build_literal();
		int          kind;
		int          sign_sel;
		int unsigned radix;
		base_t       base;
		logic [63:0] mag;
		logic [7:0]  digits[$];
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(1, 6)) begin
				txt = {txt, ($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
					: ODD_CHARS[$urandom_range(0, ODD_CHARS.len() - 1)])};
			end
			return;
		end
		sign_sel = $urandom_range(0, 2);
		if (sign_sel == 1) begin
			txt = {txt, CH_PLUS};
		end else if (sign_sel == 2) begin
			txt = {txt, CH_MINUS};
		end
		base = base_t'($urandom_range(0, 2));
		radix = (base == BASE_HEX) ? 16 : (base == BASE_OCT) ? 8 : 10;
		if (base != BASE_DEC) begin
			txt = {txt, CH_ZERO};
			txt = {txt, (base == BASE_HEX ? CH_HEX : CH_OCT)};
		end
		if (kind == 6) begin
			// Long digit strings, of 17 to 24 digits, that can run past 64 bits.
			repeat ($urandom_range(17, 24)) begin
				digits = {digits, digit_char($urandom_range(0, radix - 1))};
			end
		end else begin
			case ($urandom_range(0, 9))
				0: mag = '0;
				1: mag = MAG_LIMIT - 64'd1;
				2: mag = MAG_LIMIT;
				3: mag = MAG_LIMIT + 64'd1;
				4: mag = '1;
				5: mag = {$urandom, $urandom};
				default: mag = {$urandom, $urandom} >> $urandom_range(1, 63);
			endcase
			do begin
				digits.push_front(digit_char(int'(mag % radix)));
				mag = mag / radix;
			end while (mag != 0);
		end
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				digits.push_front(CH_ZERO);
			end
		end
		foreach (digits[i]) begin
			txt = {txt, digits[i]};
		end
		// Damage the text: overwrite a character, cut it short, or slip a character in.
		if (kind >= 7) begin
			case ($urandom_range(0, 2))
				0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
				1: begin
					if (txt.size() > 1) begin
						repeat ($urandom_range(1, txt.size() - 1)) begin
							txt.delete(txt.size() - 1);
						end
					end
				end
				default: txt.insert($urandom_range(0, txt.size()),
					ODD_CHARS[$urandom_range(0, ODD_CHARS.len() - 1)]);
			endcase
		end
	endtask

	// Input driver: holds a stalled beat, otherwise sends the next character or idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= 8'h00;
			last_char <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				scan_char(char_code, last_char);
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending.size() != 0) begin
					beat = pending.pop_front();
					in_valid <= 1'b1;
					char_code <= beat.code;
					last_char <= beat.last;
					if (!in_tail() && $urandom_range(0, 11) == 0) begin
						send_gap <= $urandom_range(1, 11);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each verdict beat and applies random stall bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_literals.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX) begin
						$display("unexpected verdict: is_integer=%0b int_value=%0d",
							is_integer, int_value);
					end
				end else begin
					want = expected_literals.pop_front();
					if (is_integer !== want.ok || int_value !== want.value) begin
						errors++;
						if (errors <= REPORT_MAX) begin
							$display({"verdict mismatch: expected is_integer=%0b ",
								"int_value=%0d, got is_integer=%0b int_value=%0d"},
								want.ok, want.value, is_integer, int_value);
						end
					end
				end
			end
			if (recv_gap != 0) begin
				out_stall <= 1'b1;
				recv_gap <= recv_gap - 1;
			end else begin
				out_stall <= 1'b0;
				if (!in_tail() && $urandom_range(0, 15) == 0) begin
					recv_gap <= $urandom_range(1, 11);
				end
			end
		end
	end

	// Watchdog: ends the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// Directed texts: signs alone, prefixes at the end or with no digit after them,
		// leading zeros, mixed-case hex, bad digits and extreme character codes.
		put_str("+");
		queue_text();
		put_str("-");
		queue_text();
		put_str("0");
		queue_text();
		put_str("0x");
		queue_text();
		put_str("0o");
		queue_text();
		put_str("0xz");
		queue_text();
		put_str("0123");
		queue_text();
		put_str("-0");
		queue_text();
		put_str("0xaF");
		queue_text();
		put_str("0o8");
		queue_text();
		txt = {txt, 8'h00};
		queue_text();
		txt = {txt, 8'hFF};
		queue_text();
		while (queued_chars < TEXT_CHARS) begin
			build_literal();
			queue_text();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid || expected_literals.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ilp_pkg.sv
rtl/integer_literal_parser.sv
sim/tb_integer_literal_parser.sv
